// ----- sv/sls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_pkg: shared types and constants
// payload structs, operation codes and sizes for the segment landing search
// ----------------------------------------------------------------------------
package sls_pkg;

   localparam int MaxLines    = 64;
   localparam int IdxWidth    = 6;
   localparam int CoordWidth  = 32;
   localparam int CountWidth  = 7;
   localparam int PointWidth  = 2 * CoordWidth;
   localparam int DiffWidth   = CoordWidth + 1;
   localparam int ProdWidth   = 2 * CoordWidth + 2;

   localparam logic [1:0] OpWrite  = 2'd0;
   localparam logic [1:0] OpSearch = 2'd1;
   localparam logic [1:0] OpFollow = 2'd2;
   localparam logic [1:0] OpUnused = 2'd3;

   typedef struct packed {
      logic [1:0]                   operation;
      logic [IdxWidth-1:0]          line_index;
      logic signed [CoordWidth-1:0] left_x;
      logic signed [CoordWidth-1:0] left_y;
      logic signed [CoordWidth-1:0] right_x;
      logic signed [CoordWidth-1:0] right_y;
      logic signed [CoordWidth-1:0] object_x;
      logic signed [CoordWidth-1:0] object_y;
   } req_type;

   typedef struct packed {
      logic                         found;
      logic signed [CoordWidth-1:0] landing_y;
      logic [IdxWidth-1:0]          hit_index;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [ProdWidth-1:0]  dividend;
      logic [DiffWidth-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [ProdWidth-1:0]  quotient;
   } div_sts_type;

endpackage

// ----- sv/sls_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_ram: generic single-port ram
// one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module sls_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- sv/sls_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_div: restoring divider
// unsigned quotient, one bit per cycle
// ----------------------------------------------------------------------------
module sls_div (
   input  logic                clock,
   input  logic                reset,
   input  sls_pkg::div_cmd_type cmd,
   output sls_pkg::div_sts_type sts
);
   import sls_pkg::*;

   localparam int CntWidth = $clog2(ProdWidth + 1);

   logic [ProdWidth-1:0] quo_ff;
   logic [DiffWidth:0]   rem_ff;
   logic [DiffWidth-1:0] den_ff;
   logic [CntWidth-1:0]  cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DiffWidth:0]   trial_in;
   logic [DiffWidth:0]   diff_in;

   always_comb begin
      trial_in = {rem_ff[DiffWidth-1:0], quo_ff[ProdWidth-1]};
      diff_in  = trial_in - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            quo_ff  <= cmd.dividend;
            den_ff  <= cmd.divisor;
            rem_ff  <= '0;
            cnt_ff  <= CntWidth'(ProdWidth);
         end else if (busy_ff) begin
            if (!diff_in[DiffWidth]) begin
               rem_ff <= diff_in;
               quo_ff <= {quo_ff[ProdWidth-2:0], 1'b1};
            end else begin
               rem_ff <= trial_in;
               quo_ff <= {quo_ff[ProdWidth-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntWidth'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

// ----- sv/segment_landing_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_landing_search_top: downward ray cast onto a segment table
// segment table in two rams, walked one entry at a time with a shared divider
// ----------------------------------------------------------------------------
// usage
//   req channel: a transfer happens when start is high and busy is low.
//   operation write loads one table entry, search walks entries 0 to
//   line_count-1 (capped at entry 63), follow evaluates the held segment
//   (searching first if none is held).
//   rsp channel: rsp_strobe is high for one cycle with the result; the
//   receiver cannot stall, so results are never held back.
//   csr channel: csr_valid/csr_ready write line_count; only while idle.
// sequencing
//   write stores the entry. each visited entry passes the address, ram
//   read and check states; a covering segment adds the multiply, divider
//   load and bit-serial divider. a search visits up to line_count entries,
//   a follow that must search first then evaluates the chosen segment.
//   one item at a time: busy stays high until the result is shown.
// reset
//   synchronous; clears line_count and the held segment. table contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module segment_landing_search_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sls_pkg::req_type    req_data,
   output logic                rsp_strobe,
   output sls_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [6:0]          csr_data
);
   import sls_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_ADDR, S_READ, S_CHECK, S_MUL, S_LOAD, S_DIV, S_NEXT,
      S_FOLLOW_RD, S_DONE
   } state_type;

   state_type                    state_ff;
   req_type                      req_ff;
   logic [CountWidth-1:0]        count_ff;
   logic [IdxWidth-1:0]          cur_ff;
   logic                         cur_valid_ff;
   logic [IdxWidth:0]            k_ff;
   logic [IdxWidth:0]            limit_ff;
   logic                         have_ff;
   logic signed [CoordWidth-1:0] best_ff;
   logic [IdxWidth-1:0]          best_k_ff;
   logic                         follow_ff;
   logic                         eval_ff;
   logic [DiffWidth-1:0]         d_ff;
   logic [DiffWidth-1:0]         a_ff;
   logic [DiffWidth-1:0]         mag_ff;
   logic                         neg_ff;
   logic signed [CoordWidth-1:0] yr_ff;
   logic [ProdWidth-1:0]         prod_ff;
   logic                         strobe_ff;
   rsp_type                      rsp_ff;
   div_cmd_type                  div_cmd;
   div_sts_type                  div_sts;

   logic                         ram_we;
   logic [IdxWidth-1:0]          ram_addr;
   logic [PointWidth-1:0]        lp_rd;
   logic [PointWidth-1:0]        rp_rd;
   logic signed [CoordWidth-1:0] xl, yl, xr, yr;
   logic signed [DiffWidth-1:0]  dy_in;
   logic                         covers_in;
   logic signed [DiffWidth:0]    y_in;
   logic signed [CoordWidth-1:0] y_res;

   assign xl = lp_rd[PointWidth-1:CoordWidth];
   assign yl = lp_rd[CoordWidth-1:0];
   assign xr = rp_rd[PointWidth-1:CoordWidth];
   assign yr = rp_rd[CoordWidth-1:0];
   assign dy_in = DiffWidth'(yr) - DiffWidth'(yl);
   assign covers_in = (xl <= req_ff.object_x) && (xr >= req_ff.object_x) && (xl != xr);

   always_comb begin
      y_in  = neg_ff ? ((DiffWidth+1)'(yr_ff) + (DiffWidth+1)'(div_sts.quotient))
                     : ((DiffWidth+1)'(yr_ff) - (DiffWidth+1)'(div_sts.quotient));
      y_res = y_in[CoordWidth-1:0];
   end

   always_comb begin
      ram_we   = (state_ff == S_WRITE);
      ram_addr = req_ff.line_index;
      if (state_ff == S_ADDR) begin
         ram_addr = k_ff[IdxWidth-1:0];
      end else if (state_ff == S_FOLLOW_RD) begin
         ram_addr = cur_ff;
      end else if (state_ff == S_READ) begin
         ram_addr = eval_ff ? cur_ff : k_ff[IdxWidth-1:0];
      end
   end

   assign div_cmd.start    = (state_ff == S_LOAD);
   assign div_cmd.dividend = prod_ff;
   assign div_cmd.divisor  = d_ff;

   sls_ram #(.Width(PointWidth), .Depth(MaxLines)) u_left_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data ({req_ff.left_x, req_ff.left_y}),
      .rd_data (lp_rd)
   );

   sls_ram #(.Width(PointWidth), .Depth(MaxLines)) u_right_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data ({req_ff.right_x, req_ff.right_y}),
      .rd_data (rp_rd)
   );

   sls_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff    <= req_data;
                  have_ff   <= 1'b0;
                  k_ff      <= '0;
                  limit_ff  <= (count_ff > CountWidth'(MaxLines))
                               ? (IdxWidth+1)'(MaxLines) : count_ff;
                  follow_ff <= (req_data.operation == OpFollow);
                  rsp_ff    <= '0;
                  case (req_data.operation)
                     OpWrite:  state_ff <= S_WRITE;
                     OpSearch: state_ff <= S_ADDR;
                     OpFollow: state_ff <= cur_valid_ff ? S_FOLLOW_RD : S_ADDR;
                     default:  state_ff <= S_DONE;
                  endcase
               end
            end
            S_WRITE: begin
               rsp_ff.hit_index <= req_ff.line_index;
               state_ff         <= S_DONE;
            end
            S_ADDR: begin
               eval_ff  <= 1'b0;
               state_ff <= (k_ff < limit_ff) ? S_READ : S_NEXT;
            end
            S_FOLLOW_RD: begin
               eval_ff  <= 1'b1;
               state_ff <= S_READ;
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               d_ff   <= DiffWidth'(xr) - DiffWidth'(xl);
               a_ff   <= DiffWidth'(xr) - DiffWidth'(req_ff.object_x);
               neg_ff <= dy_in[DiffWidth-1];
               mag_ff <= dy_in[DiffWidth-1] ? -dy_in : dy_in;
               yr_ff  <= yr;
               if (covers_in) begin
                  state_ff <= S_MUL;
               end else if (eval_ff) begin
                  rsp_ff.hit_index <= cur_ff;
                  state_ff         <= S_DONE;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_ADDR;
               end
            end
            S_MUL: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_sts.done) begin
                  if (eval_ff) begin
                     rsp_ff.found     <= 1'b1;
                     rsp_ff.landing_y <= y_res;
                     rsp_ff.hit_index <= cur_ff;
                     state_ff         <= S_DONE;
                  end else begin
                     if (y_res <= req_ff.object_y && (!have_ff || y_res > best_ff)) begin
                        have_ff   <= 1'b1;
                        best_ff   <= y_res;
                        best_k_ff <= k_ff[IdxWidth-1:0];
                     end
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_ADDR;
                  end
               end
            end
            S_NEXT: begin
               if (have_ff) begin
                  cur_ff       <= best_k_ff;
                  cur_valid_ff <= 1'b1;
               end
               if (have_ff && follow_ff) begin
                  state_ff <= S_FOLLOW_RD;
               end else begin
                  if (have_ff) begin
                     rsp_ff.found     <= 1'b1;
                     rsp_ff.landing_y <= best_ff;
                     rsp_ff.hit_index <= best_k_ff;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= ProdWidth'(mag_ff) * ProdWidth'(a_ff);
   end

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
